FILE: rtl/bda_pkg.sv
// Shared types and constants for the safety-check engine.
// No dependencies; every other file refers to it by scoped names.
package bda_pkg;

    localparam int ACTION_W  = 2;
    localparam int PROC_W    = 3;
    localparam int FIELD_W   = 8;
    localparam int VERDICT_W = 2;

    localparam int DEF_PROCESSES   = 5;
    localparam int DEF_RESOURCES   = 3;
    localparam int DEF_COUNT_WIDTH = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD_ROW = 2'd0,
        ACT_SET_FREE = 2'd1,
        ACT_REQUEST  = 2'd2,
        ACT_CHECK    = 2'd3
    } t_action;

    typedef enum logic [VERDICT_W-1:0] {
        VRD_OK          = 2'd0,
        VRD_UNSAFE      = 2'd1,
        VRD_EXCEED_FREE = 2'd2,
        VRD_EXCEED_NEED = 2'd3
    } t_verdict;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN_INIT,
        ST_SCAN,
        ST_ROLLBACK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic load_row;
        logic set_free;
        logic apply;
        logic rollback;
        logic scan_init;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic need_err;
        logic free_err;
        logic row_last;
        logic pass_last;
        logic progress_next;
        logic all_done_next;
    } t_dp_stat;

endpackage

FILE: rtl/bda_item_if.sv
// Input channel carrying one operation per transaction.
// Depends on bda_pkg for field widths.
interface bda_item_if;
    logic                          valid;
    logic                          ready;
    logic [bda_pkg::ACTION_W-1:0]  action;
    logic [bda_pkg::PROC_W-1:0]    process;
    logic [bda_pkg::FIELD_W-1:0]   amount_0;
    logic [bda_pkg::FIELD_W-1:0]   amount_1;
    logic [bda_pkg::FIELD_W-1:0]   amount_2;
    logic [bda_pkg::FIELD_W-1:0]   limit_0;
    logic [bda_pkg::FIELD_W-1:0]   limit_1;
    logic [bda_pkg::FIELD_W-1:0]   limit_2;

    modport source (
        output valid, action, process, amount_0, amount_1, amount_2,
               limit_0, limit_1, limit_2,
        input  ready
    );
    modport sink (
        input  valid, action, process, amount_0, amount_1, amount_2,
               limit_0, limit_1, limit_2,
        output ready
    );
endinterface

FILE: rtl/bda_result_if.sv
// Output channel carrying one verdict per transaction.
// Depends on bda_pkg for the verdict width.
interface bda_result_if;
    logic                           valid;
    logic                           ready;
    logic [bda_pkg::VERDICT_W-1:0]  verdict;

    modport source (output valid, verdict, input ready);
    modport sink   (input valid, verdict, output ready);
endinterface

FILE: rtl/bankers_deadlock_avoidance_top.sv
// Top level of the deadlock-avoidance engine: controller plus datapath.
// Depends on bda_pkg, bda_item_if, bda_result_if, bda_ctrl and bda_datapath.
//
// Usage: each transaction on i_item carries one operation: load a process
// row (allocation and maximum claim), set the free-unit vector, request
// units for a process, or check the current state for safety. Every input
// transaction yields exactly one verdict transaction on o_result.
// A row load, a free-unit update or a rejected request goes from decode
// straight to the output register; a safety check, or a request that
// passes its checks, runs the scan, and one found unsafe is rolled back.
// S is the number of row checks, at most PROCESSES squared.
// The scan checks one row per cycle against the work vector, so S sets the
// rate; items are taken one at a time, the next one only once the previous
// verdict is registered.
// Reset clears all allocation, need and free-unit counts to zero and
// empties the output register. When the receiver stalls, the verdict waits
// in the output register while the next item is still accepted and worked
// on; that item then waits until the register is free.
module bankers_deadlock_avoidance_top #(
    parameter int PROCESSES   = bda_pkg::DEF_PROCESSES,
    parameter int RESOURCES   = bda_pkg::DEF_RESOURCES,
    parameter int COUNT_WIDTH = bda_pkg::DEF_COUNT_WIDTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    bda_item_if.sink        i_item,
    bda_result_if.source    o_result
);

    bda_pkg::t_dp_cmd   w_cmd;
    bda_pkg::t_dp_stat  w_stat;
    bda_pkg::t_verdict  w_verdict;
    bda_pkg::t_state    w_state;
    logic               w_in_ready;
    logic               w_out_valid;

    bda_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_item.valid),
        .o_ready     (w_in_ready),
        .i_action    (i_item.action),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_result.ready),
        .o_verdict   (w_verdict),
        .o_state     (w_state)
    );

    bda_datapath #(
        .PROCESSES   (PROCESSES),
        .RESOURCES   (RESOURCES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_process  (i_item.process),
        .i_amount_0 (i_item.amount_0),
        .i_amount_1 (i_item.amount_1),
        .i_amount_2 (i_item.amount_2),
        .i_limit_0  (i_item.limit_0),
        .i_limit_1  (i_item.limit_1),
        .i_limit_2  (i_item.limit_2),
        .o_stat     (w_stat)
    );

    assign i_item.ready     = w_in_ready;
    assign o_result.valid   = w_out_valid;
    assign o_result.verdict = w_verdict;

    // Only one transaction is in flight at a time.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input accepted while an item is in progress");

    // A request is applied only when it passed both the need and free checks.
    a_apply_checked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.apply |-> (!w_stat.need_err && !w_stat.free_err))
        else $error("request applied despite a failed check");

    // A rollback immediately follows the final scan step.
    a_rollback_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.rollback |-> $past(w_cmd.scan_step))
        else $error("rollback without a preceding scan");

    // The engine leaves the idle state only by accepting an item.
    a_idle_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_state == bda_pkg::ST_IDLE) && !i_item.valid) |=>
        (w_state == bda_pkg::ST_IDLE))
        else $error("engine left idle without an input transaction");

endmodule

FILE: rtl/bda_datapath.sv
// Datapath: allocation, need and free-unit storage, request checks and the
// row-by-row safety scan. Driven by bda_ctrl through bda_pkg command structs.
module bda_datapath #(
    parameter int PROCESSES   = bda_pkg::DEF_PROCESSES,
    parameter int RESOURCES   = bda_pkg::DEF_RESOURCES,
    parameter int COUNT_WIDTH = bda_pkg::DEF_COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bda_pkg::t_dp_cmd              i_cmd,
    input  logic [bda_pkg::PROC_W-1:0]    i_process,
    input  logic [bda_pkg::FIELD_W-1:0]   i_amount_0,
    input  logic [bda_pkg::FIELD_W-1:0]   i_amount_1,
    input  logic [bda_pkg::FIELD_W-1:0]   i_amount_2,
    input  logic [bda_pkg::FIELD_W-1:0]   i_limit_0,
    input  logic [bda_pkg::FIELD_W-1:0]   i_limit_1,
    input  logic [bda_pkg::FIELD_W-1:0]   i_limit_2,
    output bda_pkg::t_dp_stat             o_stat
);

    localparam int RW = $clog2(PROCESSES);
    localparam int NW = COUNT_WIDTH + 1;
    localparam int WW = COUNT_WIDTH + 5;
    localparam int CMPW = 5;

    logic [COUNT_WIDTH-1:0]        r_held [PROCESSES][RESOURCES];
    logic signed [NW-1:0]          r_need [PROCESSES][RESOURCES];
    logic [COUNT_WIDTH-1:0]        r_free [RESOURCES];

    logic [COUNT_WIDTH-1:0]        r_want  [RESOURCES];
    logic [COUNT_WIDTH-1:0]        r_limit [RESOURCES];
    logic [RW-1:0]                 r_idx;
    logic                          r_proc_ok;

    logic [WW-1:0]                 r_work [RESOURCES];
    logic [PROCESSES-1:0]          r_done;
    logic [RW-1:0]                 r_row;
    logic [RW-1:0]                 r_pass;
    logic                          r_progress;

    logic [bda_pkg::FIELD_W-1:0]   w_amt_in [3];
    logic [bda_pkg::FIELD_W-1:0]   w_lim_in [3];
    logic                          w_fits;
    logic [PROCESSES-1:0]          w_done_nx;
    logic                          w_row_last;
    logic                          w_need_err;
    logic                          w_free_err;

    assign w_amt_in[0] = i_amount_0;
    assign w_amt_in[1] = i_amount_1;
    assign w_amt_in[2] = i_amount_2;
    assign w_lim_in[0] = i_limit_0;
    assign w_lim_in[1] = i_limit_1;
    assign w_lim_in[2] = i_limit_2;

    always_comb begin
        w_need_err = !r_proc_ok;
        w_free_err = 1'b0;
        for (int r = 0; r < RESOURCES; r++) begin
            if (signed'({1'b0, r_want[r]}) > r_need[r_idx][r]) begin
                w_need_err = 1'b1;
            end
            if (r_want[r] > r_free[r]) begin
                w_free_err = 1'b1;
            end
        end
    end

    // A row fits when it is not yet done and every positive need is covered by the work vector.
    always_comb begin
        w_fits = !r_done[r_row];
        for (int r = 0; r < RESOURCES; r++) begin
            if (!r_need[r_row][r][COUNT_WIDTH] && (r_need[r_row][r] != '0) &&
                (WW'(r_need[r_row][r][COUNT_WIDTH-1:0]) > r_work[r])) begin
                w_fits = 1'b0;
            end
        end
    end

    assign w_done_nx  = r_done | (w_fits ? (PROCESSES'(1) << r_row) : '0);
    assign w_row_last = (r_row == RW'(PROCESSES - 1));

    always_comb begin
        o_stat               = '0;
        o_stat.need_err      = w_need_err;
        o_stat.free_err      = w_free_err;
        o_stat.row_last      = w_row_last;
        o_stat.pass_last     = (r_pass == RW'(PROCESSES - 1));
        o_stat.progress_next = r_progress | w_fits;
        o_stat.all_done_next = &w_done_nx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < PROCESSES; p++) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_held[p][r] <= '0;
                    r_need[p][r] <= '0;
                end
            end
            for (int r = 0; r < RESOURCES; r++) begin
                r_free[r] <= '0;
                r_work[r] <= '0;
            end
            r_done     <= '0;
            r_row      <= '0;
            r_pass     <= '0;
            r_progress <= 1'b0;
        end else begin
            if (i_cmd.load_row && r_proc_ok) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_held[r_idx][r] <= r_want[r];
                    r_need[r_idx][r] <= signed'({1'b0, r_limit[r]}) -
                                        signed'({1'b0, r_want[r]});
                end
            end
            if (i_cmd.set_free) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_free[r] <= r_want[r];
                end
            end
            if (i_cmd.apply) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_free[r]        <= r_free[r] - r_want[r];
                    r_held[r_idx][r] <= r_held[r_idx][r] + r_want[r];
                    r_need[r_idx][r] <= r_need[r_idx][r] - signed'({1'b0, r_want[r]});
                end
            end
            if (i_cmd.rollback) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_free[r]        <= r_free[r] + r_want[r];
                    r_held[r_idx][r] <= r_held[r_idx][r] - r_want[r];
                    r_need[r_idx][r] <= r_need[r_idx][r] + signed'({1'b0, r_want[r]});
                end
            end
            if (i_cmd.scan_init) begin
                for (int r = 0; r < RESOURCES; r++) begin
                    r_work[r] <= WW'(r_free[r]);
                end
                r_done     <= '0;
                r_row      <= '0;
                r_pass     <= '0;
                r_progress <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (w_fits) begin
                    for (int r = 0; r < RESOURCES; r++) begin
                        r_work[r] <= r_work[r] + WW'(r_held[r_row][r]);
                    end
                end
                r_done <= w_done_nx;
                if (w_row_last) begin
                    r_row      <= '0;
                    r_pass     <= r_pass + 1'b1;
                    r_progress <= 1'b0;
                end else begin
                    r_row      <= r_row + 1'b1;
                    r_progress <= r_progress | w_fits;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int r = 0; r < RESOURCES; r++) begin
                r_want[r]  <= COUNT_WIDTH'(w_amt_in[r]);
                r_limit[r] <= COUNT_WIDTH'(w_lim_in[r]);
            end
            r_idx     <= RW'(i_process);
            r_proc_ok <= (CMPW'(i_process) < CMPW'(PROCESSES));
        end
    end

endmodule

FILE: rtl/bda_ctrl.sv
// Controller state machine: sequences decode, scan and rollback and holds
// the output register. Depends on bda_pkg for states, codes and structs.
module bda_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bda_pkg::ACTION_W-1:0]  i_action,
    input  bda_pkg::t_dp_stat             i_stat,
    output bda_pkg::t_dp_cmd              o_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output bda_pkg::t_verdict             o_verdict,
    output bda_pkg::t_state               o_state
);

    bda_pkg::t_state   r_state, n_state;
    bda_pkg::t_action  r_action;
    bda_pkg::t_verdict r_verdict, n_verdict;
    bda_pkg::t_verdict r_out_verdict;
    logic              r_out_valid;
    logic              w_scan_end;
    logic              w_out_load;

    assign w_scan_end = i_stat.row_last && (!i_stat.progress_next || i_stat.pass_last);

    always_comb begin
        n_state = r_state;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = bda_pkg::ST_DECODE;
                end
            end
            bda_pkg::ST_DECODE: begin
                case (r_action)
                    bda_pkg::ACT_REQUEST: begin
                        if (i_stat.need_err || i_stat.free_err) begin
                            n_state = bda_pkg::ST_FINISH;
                        end else begin
                            n_state = bda_pkg::ST_SCAN_INIT;
                        end
                    end
                    bda_pkg::ACT_CHECK: n_state = bda_pkg::ST_SCAN_INIT;
                    default:            n_state = bda_pkg::ST_FINISH;
                endcase
            end
            bda_pkg::ST_SCAN_INIT: n_state = bda_pkg::ST_SCAN;
            bda_pkg::ST_SCAN: begin
                if (w_scan_end) begin
                    if (i_stat.all_done_next || (r_action != bda_pkg::ACT_REQUEST)) begin
                        n_state = bda_pkg::ST_FINISH;
                    end else begin
                        n_state = bda_pkg::ST_ROLLBACK;
                    end
                end
            end
            bda_pkg::ST_ROLLBACK: n_state = bda_pkg::ST_FINISH;
            bda_pkg::ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = bda_pkg::ST_IDLE;
                end
            end
            default: n_state = bda_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_ready    = 1'b0;
        n_verdict  = r_verdict;
        w_out_load = 1'b0;
        case (r_state)
            bda_pkg::ST_IDLE: begin
                o_ready     = 1'b1;
                o_cmd.capture = i_valid;
            end
            bda_pkg::ST_DECODE: begin
                n_verdict = bda_pkg::VRD_OK;
                case (r_action)
                    bda_pkg::ACT_LOAD_ROW: o_cmd.load_row = 1'b1;
                    bda_pkg::ACT_SET_FREE: o_cmd.set_free = 1'b1;
                    bda_pkg::ACT_REQUEST: begin
                        if (i_stat.need_err) begin
                            n_verdict = bda_pkg::VRD_EXCEED_NEED;
                        end else if (i_stat.free_err) begin
                            n_verdict = bda_pkg::VRD_EXCEED_FREE;
                        end else begin
                            o_cmd.apply = 1'b1;
                        end
                    end
                    default: n_verdict = bda_pkg::VRD_OK;
                endcase
            end
            bda_pkg::ST_SCAN_INIT: o_cmd.scan_init = 1'b1;
            bda_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (w_scan_end) begin
                    n_verdict = i_stat.all_done_next ? bda_pkg::VRD_OK : bda_pkg::VRD_UNSAFE;
                end
            end
            bda_pkg::ST_ROLLBACK: begin
                o_cmd.rollback = 1'b1;
                n_verdict      = bda_pkg::VRD_UNSAFE;
            end
            bda_pkg::ST_FINISH: w_out_load = !r_out_valid || i_out_ready;
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bda_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_verdict <= n_verdict;
        if (o_cmd.capture) begin
            r_action <= bda_pkg::t_action'(i_action);
        end
        if (w_out_load) begin
            r_out_verdict <= r_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_out_verdict;
    assign o_state     = r_state;

endmodule
